>>> sv/fawsp_pkg.sv
// Shared types, codes and constants of the flow-affine weighted splitter.
// Used by the front end, back end and top level; depends on nothing.
package fawsp_pkg;

  // Generator constants.
  localparam logic [30:0] LCG_MUL = 31'd1103515245;
  localparam logic [13:0] LCG_ADD = 14'd12345;

  // Outcome codes.
  localparam logic [1:0] OUT_FORWARD = 2'd0;
  localparam logic [1:0] OUT_DISCARD = 2'd1;
  localparam logic [1:0] OUT_DROP    = 2'd2;

  // Rewrite codes.
  localparam logic [1:0] RW_NONE = 2'd0;
  localparam logic [1:0] RW_DST  = 2'd2;
  localparam logic [1:0] RW_BAD  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SPLIT_MODE   = 3'd0;
  localparam logic [2:0] CFG_REWRITE_MODE = 3'd1;
  localparam logic [2:0] CFG_RECV_COUNT   = 3'd2;
  localparam logic [2:0] CFG_WEIGHT_0     = 3'd3;
  localparam logic [2:0] CFG_WEIGHT_1     = 3'd4;
  localparam logic [2:0] CFG_WEIGHT_2     = 3'd5;
  localparam logic [2:0] CFG_WEIGHT_3     = 3'd6;
  localparam logic [2:0] CFG_RANDOM_SEED  = 3'd7;

  typedef struct packed {
    logic             split_mode;
    logic [1:0]       rewrite_mode;
    logic [2:0]       receiver_count;
    logic [3:0][15:0] weight;
    logic             seed_load;
    logic [31:0]      seed;
  } cfg_t;

  // One queued word: address flag and the masked flow key.
  typedef struct packed {
    logic        has_address;
    logic        kind;
    logic [63:0] key_high;
    logic [63:0] key_low;
  } item_t;

  // One flow table entry.
  typedef struct packed {
    logic        kind;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [1:0]  receiver;
    logic [31:0] client;
  } flow_ent_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [1:0]  target;
    logic [31:0] client;
    logic        first_seen;
    logic [1:0]  rewrite;
    logic [31:0] discard;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SCAN, BK_LCG_LO, BK_LCG_HI, BK_DIVIDE, BK_WALK, BK_COMMIT, BK_RESULT
  } bk_state_t;

  // A zero weight counts as one.
  function automatic logic [15:0] eff_weight(input logic [15:0] w);
    eff_weight = (w == 16'd0) ? 16'd1 : w;
  endfunction

  // Ring successor among n active positions.
  function automatic logic [1:0] next_pos(input logic [1:0] p, input logic [2:0] n);
    next_pos = ((3'(p) + 3'd1) >= n) ? 2'd0 : p + 2'd1;
  endfunction

endpackage

>>> sv/fawsp_div.sv
// Bit-serial remainder unit: 32-bit dividend modulo an 18-bit divisor.
// One quotient bit per cycle; does not use fawsp_pkg.
module fawsp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [17:0] divisor,
  output logic        done,
  output logic [17:0] rem
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [31:0] q_r, q_nxt;
  logic [18:0] r_r, r_nxt;
  logic [17:0] d_r, d_nxt;
  logic [18:0] trial;

  // Restoring step: shift in one dividend bit, subtract when it fits.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    trial    = {r_r[17:0], q_r[31]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 5'd0;
      q_nxt    = dividend;
      r_nxt    = 19'd0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      r_nxt    = (trial >= {1'b0, d_r}) ? trial - {1'b0, d_r} : trial;
      q_nxt    = {q_r[30:0], 1'b0};
      step_nxt = step_r + 5'd1;
      if (step_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign rem  = r_r[17:0];

endmodule

>>> sv/fawsp_front.sv
// Front end: accepts input words, forms the flow key and holds them in a
// two-entry queue for the back end. Depends on fawsp_pkg.
module fawsp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [127:0]         in_tdata,
  input  logic [1:0]           in_tuser,
  output logic                 q_valid,
  output fawsp_pkg::item_t     q_item,
  input  logic                 q_pop
);

  fawsp_pkg::item_t slot_r [2];
  fawsp_pkg::item_t item;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  // Classify: an IPv4 key keeps only the low 32 address bits.
  always_comb begin
    item.has_address = in_tuser[0];
    item.kind        = in_tuser[1];
    item.key_high    = in_tuser[1] ? in_tdata[63:0] : 64'd0;
    item.key_low     = in_tuser[1] ? in_tdata[127:64] : {32'd0, in_tdata[95:64]};
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = slot_r[rd_ptr_r];

  // Queue pointers and fill level.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= item;
    end
  end

endmodule

>>> sv/fawsp_back.sv
// Back end: flow table scan, receiver choice, table fill and result word.
// Depends on fawsp_pkg and fawsp_div.
module fawsp_back #(
  parameter int FLOW_ENTRIES  = 1024,
  parameter int MAX_RECEIVERS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fawsp_pkg::cfg_t  cfg,
  input  logic             q_valid,
  input  fawsp_pkg::item_t q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output fawsp_pkg::res_t  out_res
);

  localparam int AW = $clog2(FLOW_ENTRIES);

  fawsp_pkg::flow_ent_t mem [FLOW_ENTRIES];

  fawsp_pkg::bk_state_t state_r, state_nxt;
  fawsp_pkg::item_t     item_r, item_nxt;
  fawsp_pkg::flow_ent_t rd_r;
  fawsp_pkg::res_t      res_r, res_nxt, out_r, out_nxt;
  fawsp_pkg::flow_ent_t wr_ent;
  logic [AW:0]        fill_r, fill_nxt, idx_r, idx_nxt;
  logic               pend_r, pend_nxt;
  logic               go_r, go_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         ring_r, ring_nxt, pos_r, pos_nxt;
  logic [31:0]        cnt_r [4];
  logic [31:0]        cnt_nxt [4];
  logic [47:0]        gen_r, gen_nxt, prod_r, prod_nxt;
  logic [31:0]        disc_r, disc_nxt;
  logic signed [19:0] rem_r, rem_nxt, rem_step;
  logic [2:0]         k_r, k_nxt;
  logic [2:0]         n_act;
  logic [1:0]         pos_eff, rw;
  logic [17:0]        total;
  logic               issue, hit, miss, full, mem_we;
  logic               div_done;
  logic [17:0]        div_rem;
  logic [47:0]        hi_part;

  // Active receiver count, start position, total weight and rewrite code.
  always_comb begin
    n_act = cfg.receiver_count;
    if (n_act == 3'd0) n_act = 3'd1;
    if (n_act > 3'(MAX_RECEIVERS)) n_act = 3'(MAX_RECEIVERS);
    pos_eff = ({1'b0, ring_r} < n_act) ? ring_r : 2'd0;
    total = 18'd0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < n_act) total = total + 18'(fawsp_pkg::eff_weight(cfg.weight[k]));
    end
    rw = (cfg.rewrite_mode == fawsp_pkg::RW_BAD) ? fawsp_pkg::RW_NONE : cfg.rewrite_mode;
  end

  // Scan pipeline: read one entry a cycle, compare the one read before.
  assign issue = (idx_r < fill_r);
  assign hit   = pend_r && (rd_r.kind == item_r.kind) && (rd_r.key_high == item_r.key_high)
                 && (rd_r.key_low == item_r.key_low);
  assign miss  = !hit && !issue;
  assign full  = (fill_r == (AW + 1)'(FLOW_ENTRIES));

  fawsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go_r),
    .dividend (cfg.split_mode ? gen_r[47:16] : cnt_r[pos_r]),
    .divisor  (cfg.split_mode ? total : {2'b00, fawsp_pkg::eff_weight(cfg.weight[pos_r])}),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fawsp_pkg::BK_IDLE:
        if (q_valid) state_nxt = q_item.has_address ? fawsp_pkg::BK_SCAN : fawsp_pkg::BK_RESULT;
      fawsp_pkg::BK_SCAN:
        if (hit || (miss && full)) state_nxt = fawsp_pkg::BK_RESULT;
        else if (miss) state_nxt = cfg.split_mode ? fawsp_pkg::BK_LCG_LO : fawsp_pkg::BK_DIVIDE;
      fawsp_pkg::BK_LCG_LO: state_nxt = fawsp_pkg::BK_LCG_HI;
      fawsp_pkg::BK_LCG_HI: state_nxt = fawsp_pkg::BK_DIVIDE;
      fawsp_pkg::BK_DIVIDE:
        if (div_done && !go_r) state_nxt = cfg.split_mode ? fawsp_pkg::BK_WALK :
                                                          fawsp_pkg::BK_COMMIT;
      fawsp_pkg::BK_WALK:
        if (!((k_r < n_act) && (rem_r > 20'sd0))) state_nxt = fawsp_pkg::BK_COMMIT;
      fawsp_pkg::BK_COMMIT: state_nxt = fawsp_pkg::BK_RESULT;
      fawsp_pkg::BK_RESULT:
        if (!out_valid_r || out_ready) state_nxt = fawsp_pkg::BK_IDLE;
      default: state_nxt = fawsp_pkg::BK_IDLE;
    endcase
  end

  // Datapath and outputs per state.
  always_comb begin
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    go_nxt        = 1'b0;
    ring_nxt      = ring_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    gen_nxt       = gen_r;
    prod_nxt      = prod_r;
    disc_nxt      = disc_r;
    rem_nxt       = rem_r;
    k_nxt         = k_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    rem_step      = rem_r - 20'(fawsp_pkg::eff_weight(cfg.weight[pos_r]));
    hi_part       = {24'(gen_r[47:24] * fawsp_pkg::LCG_MUL), 24'd0};
    wr_ent        = '{kind: item_r.kind, key_high: item_r.key_high, key_low: item_r.key_low,
                      receiver: pos_r, client: cnt_r[pos_r]};
    if (cfg.seed_load) gen_nxt = {16'd0, cfg.seed};
    case (state_r)
      fawsp_pkg::BK_IDLE: begin
        q_pop    = q_valid;
        item_nxt = q_item;
        idx_nxt  = '0;
        if (q_valid && !q_item.has_address) begin
          disc_nxt = disc_r + 32'd1;
          res_nxt  = '{outcome: fawsp_pkg::OUT_DISCARD, target: 2'd0, client: 32'd0,
                       first_seen: 1'b0, rewrite: fawsp_pkg::RW_NONE, discard: disc_r + 32'd1};
        end
      end
      fawsp_pkg::BK_SCAN: begin
        idx_nxt  = issue ? idx_r + 1'b1 : idx_r;
        pend_nxt = issue && !hit;
        pos_nxt  = pos_eff;
        if (hit) begin
          res_nxt = '{outcome: fawsp_pkg::OUT_FORWARD, target: rd_r.receiver,
                      client: rd_r.client, first_seen: 1'b0, rewrite: rw, discard: disc_r};
        end else if (miss && full) begin
          res_nxt = '{outcome: fawsp_pkg::OUT_DROP, target: 2'd0, client: 32'd0,
                      first_seen: 1'b0, rewrite: fawsp_pkg::RW_NONE, discard: disc_r};
        end else if (miss && !cfg.split_mode) begin
          cnt_nxt[pos_eff] = cnt_r[pos_eff] + 32'd1;
          go_nxt = 1'b1;
        end
      end
      fawsp_pkg::BK_LCG_LO:
        prod_nxt = 48'(gen_r[23:0] * fawsp_pkg::LCG_MUL);
      fawsp_pkg::BK_LCG_HI: begin
        gen_nxt = prod_r + hi_part + 48'(fawsp_pkg::LCG_ADD);
        go_nxt  = 1'b1;
      end
      fawsp_pkg::BK_DIVIDE:
        if (div_done && !go_r) begin
          rem_nxt = 20'(div_rem) + 20'sd1;
          k_nxt   = 3'd0;
          if (!cfg.split_mode) begin
            ring_nxt = (div_rem == 18'd0) ? fawsp_pkg::next_pos(pos_r, n_act) : pos_r;
          end
        end
      fawsp_pkg::BK_WALK:
        if ((k_r < n_act) && (rem_r > 20'sd0)) begin
          rem_nxt = rem_step;
          k_nxt   = k_r + 3'd1;
          if (rem_step > 20'sd0) pos_nxt = fawsp_pkg::next_pos(pos_r, n_act);
        end else begin
          cnt_nxt[pos_r] = cnt_r[pos_r] + 32'd1;
          ring_nxt       = pos_r;
        end
      fawsp_pkg::BK_COMMIT: begin
        mem_we   = 1'b1;
        fill_nxt = fill_r + 1'b1;
        res_nxt  = '{outcome: fawsp_pkg::OUT_FORWARD, target: pos_r, client: cnt_r[pos_r],
                     first_seen: 1'b1, rewrite: rw, discard: disc_r};
      end
      fawsp_pkg::BK_RESULT:
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
        end
      default: ;
    endcase
  end

  // Flow table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) mem[fill_r[AW-1:0]] <= wr_ent;
    if (issue) rd_r <= mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fawsp_pkg::BK_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      ring_r      <= 2'd0;
      for (int i = 0; i < 4; i++) cnt_r[i] <= 32'd0;
      gen_r       <= 48'd1;
      disc_r      <= 32'd0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
      ring_r      <= ring_nxt;
      cnt_r       <= cnt_nxt;
      gen_r       <= gen_nxt;
      disc_r      <= disc_nxt;
    end
    item_r <= item_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
    pos_r  <= pos_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    k_r    <= k_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

>>> sv/flow_affine_weighted_splitter.sv
// Top level of the flow-affine weighted splitter: configuration registers,
// front end with queue, and back end. Depends on fawsp_pkg, fawsp_front, fawsp_back.
//
// Each word carries one packet's source address; the block returns one result word
// per input word, in order. A word without an address goes straight from idle to
// the back end's result state. A word with an address scans the flow table one
// entry per cycle through the flow memory's read port and stops at a hit. A new
// flow adds the bit-serial remainder unit; in random mode the two-step generator
// multiply comes before it and a walk over the receiver ring after it. The flow
// table fills in order; only reset empties it, by zeroing the fill count, with no
// clearing pass. The two-word queue lets the input keep accepting while the back
// end works, and the output register holds a result until taken.
module flow_affine_weighted_splitter #(
  parameter int FLOW_ENTRIES  = 1024,
  parameter int MAX_RECEIVERS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // source_high, source_low
  input  logic [1:0]   in_tuser,   // has_address, is_version_six
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // target_receiver, client_number, first_seen,
                                   // rewrite_target, discard_total, zero fill
  output logic [1:0]   out_tuser,  // outcome
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  fawsp_pkg::cfg_t  cfg_r, cfg_nxt;
  fawsp_pkg::item_t q_item;
  fawsp_pkg::res_t  res;
  logic             q_valid, q_pop;

  // Configuration register writes.
  always_comb begin
    cfg_nxt           = cfg_r;
    cfg_nxt.seed_load = 1'b0;
    cfg_nxt.seed      = cfg_wdata;
    if (cfg_wr_en) begin
      case (cfg_index)
        fawsp_pkg::CFG_SPLIT_MODE:   cfg_nxt.split_mode     = cfg_wdata[0];
        fawsp_pkg::CFG_REWRITE_MODE: cfg_nxt.rewrite_mode   = cfg_wdata[1:0];
        fawsp_pkg::CFG_RECV_COUNT:   cfg_nxt.receiver_count = cfg_wdata[2:0];
        fawsp_pkg::CFG_WEIGHT_0:     cfg_nxt.weight[0]      = cfg_wdata[15:0];
        fawsp_pkg::CFG_WEIGHT_1:     cfg_nxt.weight[1]      = cfg_wdata[15:0];
        fawsp_pkg::CFG_WEIGHT_2:     cfg_nxt.weight[2]      = cfg_wdata[15:0];
        fawsp_pkg::CFG_WEIGHT_3:     cfg_nxt.weight[3]      = cfg_wdata[15:0];
        fawsp_pkg::CFG_RANDOM_SEED:  cfg_nxt.seed_load      = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.split_mode     <= 1'b0;
      cfg_r.rewrite_mode   <= fawsp_pkg::RW_NONE;
      cfg_r.receiver_count <= 3'd1;
      cfg_r.weight         <= {4{16'd1}};
      cfg_r.seed_load      <= 1'b0;
    end else begin
      cfg_r.split_mode     <= cfg_nxt.split_mode;
      cfg_r.rewrite_mode   <= cfg_nxt.rewrite_mode;
      cfg_r.receiver_count <= cfg_nxt.receiver_count;
      cfg_r.weight         <= cfg_nxt.weight;
      cfg_r.seed_load      <= cfg_nxt.seed_load;
    end
    cfg_r.seed <= cfg_nxt.seed;
  end

  fawsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  fawsp_back #(
    .FLOW_ENTRIES  (FLOW_ENTRIES),
    .MAX_RECEIVERS (MAX_RECEIVERS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Result word packing.
  assign out_tdata = {3'd0, res.discard, res.rewrite, res.first_seen, res.client, res.target};
  assign out_tuser = res.outcome;

endmodule

>>> sv/fawsp_checker.sv
// Port-level checks of the splitter's result channel, bound to the top level.
// Depends on flow_affine_weighted_splitter's ports only.
module fawsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result word holds still.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // No result appears in the cycle after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The outcome code never takes its unused value.
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("unused outcome code");

  // Discarded and dropped words carry no receiver, client, first-seen flag or rewrite.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == 2'd1 || out_tuser == 2'd2) |-> out_tdata[36:0] == 37'd0)
    else $error("non-forwarded word carries flow fields");

  // Pad bits stay clear.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71:69] == 3'd0)
    else $error("pad bits set");

endmodule

bind flow_affine_weighted_splitter fawsp_checker u_fawsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
